// ===== sv/rcpa_pkg.sv =====
// Shared types, field widths and codes for the reference-counted page allocator.
// No dependencies; rcpa_scan, refcounted_page_allocator and rcpa_checker import this package.
package rcpa_pkg;

	// Default sizes
	localparam int RCPA_PAGE_COUNT = 512;
	localparam int RCPA_COUNT_BITS = 8;

	// Page geometry (a power of two: page number is the address shifted down)
	localparam int RCPA_PAGE_BYTES = 4096;
	localparam int RCPA_PAGE_SHIFT = 12;

	// Field widths
	localparam int ACTION_W  = 2;
	localparam int REQ_W     = 16;
	localparam int ADDR_W    = 21;
	localparam int STATUS_W  = 3;
	localparam int NCOUNT_W  = 8;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;

	// Actions
	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_BORROW = 2'd2;

	// Result status
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_USABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_USABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED     = 2'd2;

	localparam logic [CFG_W-1:0] FIRST_USABLE_RST = 9'd256;
	localparam logic [CFG_W-1:0] LAST_USABLE_RST  = 9'd511;
	localparam logic [CFG_W-1:0] EXCLUDED_RST     = 9'd184;

	typedef struct packed {
		logic [CFG_W-1:0] first_usable;
		logic [CFG_W-1:0] last_usable;
		logic [CFG_W-1:0] excluded;
	} cfg_t;

endpackage

// ===== sv/rcpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/rcpa_scan.sv =====
// Candidate search over one word of the held bitmap: window, exclusion and
// range compares per bit, then a lowest-first priority pick. Uses rcpa_pkg.
module rcpa_scan import rcpa_pkg::*; #(
	parameter int PAGE_COUNT = RCPA_PAGE_COUNT,
	parameter int WORD_BITS  = 32,
	parameter int WW         = 4
) (
	input  logic [WW-1:0]                  word,
	input  logic [WORD_BITS-1:0]           held,
	input  cfg_t                           cfg,
	output logic                           found,
	output logic [$clog2(WORD_BITS)-1:0]   pick
);

	localparam int BB = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] cand;
	logic [31:0]          base;

	assign base = 32'(word) << BB;

	always_comb begin
		logic [31:0] p;
		for (int b = 0; b < WORD_BITS; b++) begin
			p = base | 32'(b);
			cand[b] = !held[b] && (p >= 32'(cfg.first_usable)) &&
				(p <= 32'(cfg.last_usable)) && (p != 32'(cfg.excluded)) &&
				(p < 32'(PAGE_COUNT));
		end
	end

	// lowest set candidate wins
	always_comb begin
		pick = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				pick = BB'(b);
			end
		end
	end

	assign found = |cand;

endmodule

// ===== sv/refcounted_page_allocator.sv =====
// Reference-counted physical page allocator: sequencer, held bitmap, count store.
// Depends on rcpa_pkg, rcpa_ram and rcpa_scan.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item: action, request_bytes,
//   page_address. Output channel (out_valid/out_stall) returns one item per
//   input: status, result_address, new_count. Config channel (cfg_valid,
//   cfg_ready, cfg_index, cfg_data) writes the page window and excluded page;
//   cfg_ready is always high, write only while the block is idle.
//   Sequence: free and borrow go through the decode, read and evaluate states
//   before the result is registered; allocate reads and evaluates one 32-page
//   bitmap word at a time, from the word holding first_usable_page up to the
//   first free page. Errors detected from the address or size alone are
//   reported from the decode state. One item is in work at a time; the
//   held-bitmap read port and the 32-bit candidate search set the allocate time.
//   Reset: counts read as zero after reset; a clearing pass writes every word
//   of the held bitmap, during which in_stall stays high.
//   A stalled result holds in the output register; the next item is accepted
//   meanwhile and waits for the register before it completes.
module refcounted_page_allocator import rcpa_pkg::*; #(
	parameter int PAGE_COUNT = RCPA_PAGE_COUNT,
	parameter int COUNT_BITS = RCPA_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [REQ_W-1:0]      request_bytes,
	input  logic [ADDR_W-1:0]     page_address,
	// results
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [ADDR_W-1:0]     result_address,
	output logic [NCOUNT_W-1:0]   new_count,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int WORD_BITS = (PAGE_COUNT >= 32) ? 32 : (1 << $clog2(PAGE_COUNT));
	localparam int BB        = $clog2(WORD_BITS);
	localparam int WORDS     = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PGW       = $clog2(PAGE_COUNT);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EV   = 3'd4;

	logic [2:0]          state_q, state_d;
	logic [WW-1:0]       word_q, word_d;
	logic [ACTION_W-1:0] action_q;
	logic [REQ_W-1:0]    req_q;
	logic [ADDR_W-1:0]   addr_q;
	cfg_t                cfg_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   raddr_q;
	logic [NCOUNT_W-1:0] cnt_out_q;

	// RAM ports
	logic                  bm_we;
	logic [WW-1:0]         bm_waddr;
	logic [WORD_BITS-1:0]  bm_wdata, bm_rdata;
	logic                  cnt_we;
	logic [PGW-1:0]        cnt_waddr, cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

	// scan unit
	logic          scan_found;
	logic [BB-1:0] scan_pick;

	// decode of the held item
	logic [31:0]           page32, first_word32, alloc_page32, cnt_ext;
	logic                  misaligned, out_range, too_large, last_word;
	logic [BB-1:0]         bit_sel;
	logic                  held;
	logic [COUNT_BITS-1:0] cnt_cur, cnt_dec, cnt_inc;
	logic [WORD_BITS-1:0]  bit_onehot, pick_onehot;

	// result to load
	logic                  can_put, put;
	logic [STATUS_W-1:0]   put_status;
	logic [ADDR_W-1:0]     put_addr;
	logic [COUNT_BITS-1:0] put_cnt;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign can_put   = !out_valid_q || !out_stall;

	assign page32       = 32'(addr_q >> RCPA_PAGE_SHIFT);
	assign misaligned   = (addr_q[RCPA_PAGE_SHIFT-1:0] != '0);
	assign out_range    = (page32 >= 32'(PAGE_COUNT));
	assign too_large    = ({1'b0, req_q} > 17'(RCPA_PAGE_BYTES));
	assign first_word32 = 32'(cfg_q.first_usable) >> BB;
	assign last_word    = (word_q == WW'(WORDS - 1)) ||
		(32'(word_q) >= (32'(cfg_q.last_usable) >> BB));
	assign bit_sel      = page32[BB-1:0];
	assign held         = bm_rdata[bit_sel];
	assign cnt_cur      = held ? cnt_rdata : '0;
	assign cnt_dec      = cnt_cur - COUNT_ONE;
	assign cnt_inc      = cnt_cur + COUNT_ONE;
	assign bit_onehot   = WORD_BITS'(1) << bit_sel;
	assign pick_onehot  = WORD_BITS'(1) << scan_pick;
	assign alloc_page32 = (32'(word_q) << BB) | 32'(scan_pick);
	assign cnt_raddr    = page32[PGW-1:0];

	rcpa_scan #(
		.PAGE_COUNT(PAGE_COUNT),
		.WORD_BITS (WORD_BITS),
		.WW        (WW)
	) u_scan (
		.word (word_q),
		.held (bm_rdata),
		.cfg  (cfg_q),
		.found(scan_found),
		.pick (scan_pick)
	);

	rcpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS)
	) u_held_ram (
		.clk  (clk),
		.we   (bm_we),
		.waddr(bm_waddr),
		.wdata(bm_wdata),
		.raddr(word_q),
		.rdata(bm_rdata)
	);

	rcpa_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(PAGE_COUNT)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	always_comb begin
		state_d    = state_q;
		word_d     = word_q;
		bm_we      = 1'b0;
		bm_waddr   = word_q;
		bm_wdata   = '0;
		cnt_we     = 1'b0;
		cnt_waddr  = page32[PGW-1:0];
		cnt_wdata  = cnt_dec;
		put        = 1'b0;
		put_status = ST_OK;
		put_addr   = '0;
		put_cnt    = '0;
		case (state_q)
			S_CLR: begin
				bm_we = 1'b1;
				word_d = word_q + WW'(1);
				if (word_q == WW'(WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (action_q == ACT_ALLOC) begin
					if (too_large) begin
						put = can_put;
						put_status = ST_TOO_LARGE;
					end else if (first_word32 >= 32'(WORDS)) begin
						put = can_put;
						put_status = ST_NONE_FREE;
					end else begin
						word_d = first_word32[WW-1:0];
						state_d = S_RD;
					end
				end else if (action_q != ACT_FREE && action_q != ACT_BORROW) begin
					put = can_put;
				end else if (action_q == ACT_FREE && addr_q == '0) begin
					put = can_put;
				end else if (misaligned || out_range) begin
					put = can_put;
					put_status = ST_BAD_ADDR;
				end else begin
					word_d = page32[BB +: WW];
					state_d = S_RD;
				end
				if (put) begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				state_d = S_EV;
			end
			S_EV: begin
				if (action_q == ACT_ALLOC) begin
					if (scan_found) begin
						put = can_put;
						put_addr = ADDR_W'(alloc_page32 << RCPA_PAGE_SHIFT);
						put_cnt = COUNT_ONE;
						bm_we = put;
						bm_wdata = bm_rdata | pick_onehot;
						cnt_we = put;
						cnt_waddr = alloc_page32[PGW-1:0];
						cnt_wdata = COUNT_ONE;
					end else if (last_word) begin
						put = can_put;
						put_status = ST_NONE_FREE;
					end else begin
						// advance to the next bitmap word
						word_d = word_q + WW'(1);
						state_d = S_RD;
					end
				end else if (!held) begin
					put = can_put;
					put_status = ST_NOT_HELD;
				end else if (action_q == ACT_FREE) begin
					put = can_put;
					put_cnt = cnt_dec;
					cnt_we = put;
					bm_we = put && (cnt_dec == '0);
					bm_wdata = bm_rdata & ~bit_onehot;
				end else if (cnt_cur == COUNT_MAX) begin
					put = can_put;
					put_status = ST_SATURATED;
					put_cnt = cnt_cur;
				end else begin
					put = can_put;
					put_addr = addr_q;
					put_cnt = cnt_inc;
					cnt_we = put;
					cnt_wdata = cnt_inc;
				end
				if (put) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cnt_ext = 32'(put_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			cfg_q.first_usable <= FIRST_USABLE_RST;
			cfg_q.last_usable  <= LAST_USABLE_RST;
			cfg_q.excluded     <= EXCLUDED_RST;
		end else begin
			state_q <= state_d;
			word_q  <= word_d;
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_FIRST_USABLE: cfg_q.first_usable <= cfg_data;
					REG_LAST_USABLE:  cfg_q.last_usable  <= cfg_data;
					REG_EXCLUDED:     cfg_q.excluded     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			action_q <= action;
			req_q    <= request_bytes;
			addr_q   <= page_address;
		end
		if (put) begin
			status_q  <= put_status;
			raddr_q   <= put_addr;
			cnt_out_q <= cnt_ext[NCOUNT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = raddr_q;
	assign new_count      = cnt_out_q;

endmodule

// ===== sv/rcpa_checker.sv =====
// Port-level checks for the page allocator, bound to the top level.
// Depends on rcpa_pkg and refcounted_page_allocator.
module rcpa_checker import rcpa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [ACTION_W-1:0]  action,
	input logic [REQ_W-1:0]     request_bytes,
	input logic [ADDR_W-1:0]    page_address,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [STATUS_W-1:0]  status,
	input logic [ADDR_W-1:0]    result_address,
	input logic [NCOUNT_W-1:0]  new_count,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(result_address) && $stable(new_count))
		else $error("stalled result changed");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a second item while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_SATURATED)
		else $error("status code out of range");

	// a failure never hands out an address
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_address == '0)
		else $error("address returned on failure");

	// a handed-out or borrowed page is held
	a_addr_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && result_address != '0 |-> new_count != '0)
		else $error("page returned with zero count");

endmodule

bind refcounted_page_allocator rcpa_checker u_rcpa_checker (.*);
